// ===== sv/tpva_pkg.sv =====
// shared types, constants and helper functions for the tube prism volume accumulator
`default_nettype none

package tpva_pkg;

	// widths fixed by the stream format
	localparam int COORD_IN_BITS = 16;
	localparam int SUM_BITS      = 64;
	localparam int VOL_BITS      = 63;

	// micro-op sequencing: nine products per tetrahedron, three tetrahedra per prism
	localparam int NUM_OPS  = 9;
	localparam int OP_BITS  = 4;
	localparam logic [OP_BITS-1:0] LAST_OP = OP_BITS'(NUM_OPS - 1);

	// divide by six, one hex digit per step
	localparam int DIVISOR     = 6;
	localparam int DIV_DIGIT   = 4;
	localparam int DIV_STEPS   = SUM_BITS / DIV_DIGIT;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);
	localparam int REM_BITS    = 3;
	localparam int DIG_BITS    = REM_BITS + DIV_DIGIT;
	// floor(v * 43 / 256) == floor(v / 6) for every v below 96
	localparam int DIV_RECIP   = 43;
	localparam int RECIP_SHIFT = 8;

	typedef enum logic [1:0] {
		VEC_U,
		VEC_V,
		VEC_W,
		VEC_X
	} vec_t;

	typedef enum logic [1:0] {
		DST_X0,
		DST_X1,
		DST_X2,
		DST_T
	} dst_t;

	typedef enum logic [1:0] {
		MD_LOAD,
		MD_ADD,
		MD_SUB
	} mode_t;

	typedef enum logic [1:0] {
		TET_ABCE,
		TET_ADEF,
		TET_CEFA
	} tet_t;

	typedef struct packed {
		vec_t       a_vec;
		logic [1:0] a_comp;
		vec_t       b_vec;
		logic [1:0] b_comp;
		dst_t       dst;
		mode_t      mode;
		logic       tet_end;
	} uop_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic load_diff;
		tet_t tet;
		logic issue;
		uop_t uop;
		logic store_prev;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic have_prev;
		logic out_free;
	} status_t;

	// cross product x = v * w into x0..x2, then dot product u . x into t
	function automatic uop_t uop_of(input logic [OP_BITS-1:0] op);
		uop_t u;
		u = '0;
		case (op)
			4'd0: u = '{a_vec: VEC_V, a_comp: 2'd1, b_vec: VEC_W, b_comp: 2'd2,
				dst: DST_X0, mode: MD_LOAD, tet_end: 1'b0};
			4'd1: u = '{a_vec: VEC_W, a_comp: 2'd1, b_vec: VEC_V, b_comp: 2'd2,
				dst: DST_X0, mode: MD_SUB, tet_end: 1'b0};
			4'd2: u = '{a_vec: VEC_V, a_comp: 2'd2, b_vec: VEC_W, b_comp: 2'd0,
				dst: DST_X1, mode: MD_LOAD, tet_end: 1'b0};
			4'd3: u = '{a_vec: VEC_W, a_comp: 2'd2, b_vec: VEC_V, b_comp: 2'd0,
				dst: DST_X1, mode: MD_SUB, tet_end: 1'b0};
			4'd4: u = '{a_vec: VEC_V, a_comp: 2'd0, b_vec: VEC_W, b_comp: 2'd1,
				dst: DST_X2, mode: MD_LOAD, tet_end: 1'b0};
			4'd5: u = '{a_vec: VEC_W, a_comp: 2'd0, b_vec: VEC_V, b_comp: 2'd1,
				dst: DST_X2, mode: MD_SUB, tet_end: 1'b0};
			4'd6: u = '{a_vec: VEC_U, a_comp: 2'd0, b_vec: VEC_X, b_comp: 2'd0,
				dst: DST_T, mode: MD_LOAD, tet_end: 1'b0};
			4'd7: u = '{a_vec: VEC_U, a_comp: 2'd1, b_vec: VEC_X, b_comp: 2'd1,
				dst: DST_T, mode: MD_ADD, tet_end: 1'b0};
			4'd8: u = '{a_vec: VEC_U, a_comp: 2'd2, b_vec: VEC_X, b_comp: 2'd2,
				dst: DST_T, mode: MD_ADD, tet_end: 1'b1};
			default: u = '0;
		endcase
		return u;
	endfunction

	// quotient digit of a 7-bit partial dividend by six
	function automatic logic [DIV_DIGIT-1:0] quo6(input logic [DIG_BITS-1:0] v);
		logic [12:0] p;
		p = 13'(v) * 13'(DIV_RECIP);
		return p[RECIP_SHIFT +: DIV_DIGIT];
	endfunction

endpackage

`default_nettype wire

// ===== sv/tpva_tri_if.sv =====
// input channel carrying one cross-section triangle per word
`default_nettype none

interface tpva_tri_if;
	logic valid;
	logic ready;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] ax;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] ay;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] az;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] bx;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] by_coord;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] bz;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] cx;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] cy;
	logic signed [tpva_pkg::COORD_IN_BITS-1:0] cz;
	logic first;
	logic last;

	modport source (
		output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, first, last,
		input  ready
	);

	modport sink (
		input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, first, last,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/tpva_res_if.sv =====
// result channel carrying one tube volume per word
`default_nettype none

interface tpva_res_if;
	logic valid;
	logic ready;
	logic [tpva_pkg::VOL_BITS-1:0] volume;
	logic saturated;

	modport source (
		output valid, volume, saturated,
		input  ready
	);

	modport sink (
		input  valid, volume, saturated,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/tpva_ctrl.sv =====
// sequencer that steps the shared multiplier, the divider and the result handoff
`default_nettype none

module tpva_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  logic               first,
	input  logic               last,
	output logic               ready,
	input  tpva_pkg::status_t  status,
	output tpva_pkg::cmd_t     cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOAD  = 6'b000010,
		S_CALC  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                              state_q, state_d;
	logic [1:0]                          tet_q, tet_d;
	logic [tpva_pkg::OP_BITS-1:0]        op_q, op_d;
	logic [tpva_pkg::DIV_CNT_BITS-1:0]   cnt_q, cnt_d;
	logic                                last_q, last_d;

	always_comb begin
		state_d = state_q;
		tet_d   = tet_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		last_d  = last_q;
		cmd     = '0;
		ready   = 1'b0;
		cmd.tet = tpva_pkg::tet_t'(tet_q);
		case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (valid) begin
					cmd.accept = 1'b1;
					cmd.clear  = first;
					last_d     = last;
					if (status.have_prev && !first) begin
						tet_d   = 2'(tpva_pkg::TET_ABCE);
						state_d = S_LOAD;
					end else begin
						state_d = S_DRAIN;
					end
				end
			end
			S_LOAD: begin
				cmd.load_diff = 1'b1;
				op_d          = '0;
				state_d       = S_CALC;
			end
			S_CALC: begin
				cmd.issue = 1'b1;
				cmd.uop   = tpva_pkg::uop_of(op_q);
				if (op_q == tpva_pkg::LAST_OP) begin
					if (tet_q == 2'(tpva_pkg::TET_CEFA)) begin
						state_d = S_DRAIN;
					end else begin
						tet_d   = tet_q + 2'd1;
						state_d = S_LOAD;
					end
				end else begin
					op_d = op_q + 1'b1;
				end
			end
			S_DRAIN: begin
				// wait for the last tetrahedron to land in the sum
				if (!status.busy) begin
					cmd.store_prev = 1'b1;
					if (last_q) begin
						cmd.div_load = 1'b1;
						cnt_d        = '0;
						state_d      = S_DIV;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == tpva_pkg::DIV_LAST) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tet_q   <= '0;
			op_q    <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tet_q   <= tet_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
		end
	end

	a_ready_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> !status.busy)
		else $error("new word taken while products are still in flight");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded over a word not yet taken");

	a_issue_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.uop.mode == tpva_pkg::MD_LOAD && cmd.uop.dst == tpva_pkg::DST_X0)
		|-> $past(cmd.load_diff))
		else $error("tetrahedron started without fresh edge vectors");

endmodule

`default_nettype wire

// ===== sv/tpva_dp.sv =====
// datapath: corner store, edge vectors, shared multiplier, accumulators, divider, result register
`default_nettype none

module tpva_dp #(
	parameter int COORD_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] ax,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] ay,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] az,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] bx,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] by_coord,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] bz,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] cx,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] cy,
	input  logic signed [tpva_pkg::COORD_IN_BITS-1:0] cz,
	input  tpva_pkg::cmd_t                         cmd,
	output tpva_pkg::status_t                      status,
	tpva_res_if.source                             result
);

	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 1;
	localparam int XW  = 2 * DW + 1;
	localparam int PW  = DW + XW;
	localparam int TW  = PW + 2;
	localparam int EXT = (CW > tpva_pkg::COORD_IN_BITS) ? CW : tpva_pkg::COORD_IN_BITS;
	localparam int SB  = tpva_pkg::SUM_BITS;

	logic signed [CW-1:0] cur_q  [0:2][0:2];
	logic signed [CW-1:0] prev_q [0:2][0:2];
	logic signed [DW-1:0] u_q [0:2];
	logic signed [DW-1:0] v_q [0:2];
	logic signed [DW-1:0] w_q [0:2];
	logic signed [XW-1:0] x_q [0:2];
	logic signed [TW-1:0] t_q;

	logic signed [DW-1:0] opa;
	logic signed [XW-1:0] opb;
	logic signed [DW-1:0] opa_s1;
	logic signed [XW-1:0] opb_s1;
	tpva_pkg::uop_t       uop_s1;
	logic                 v_s1;
	logic signed [PW-1:0] prod_s2;
	tpva_pkg::uop_t       uop_s2;
	logic                 v_s2;
	logic                 tend_s3;
	logic [TW-1:0]        abs_s4;
	logic                 abs_v_s4;

	logic [SB-1:0]        sum_q;
	logic [SB:0]          sum_ext;
	logic                 sat_q;
	logic                 have_prev_q;

	logic [SB-1:0]                       div_q;
	logic [tpva_pkg::REM_BITS-1:0]       rem_q;
	logic [tpva_pkg::DIG_BITS-1:0]       dig;
	logic [tpva_pkg::DIV_DIGIT-1:0]      qdig;
	logic [tpva_pkg::DIG_BITS-1:0]       qmul;

	logic                                out_valid_q;
	logic [tpva_pkg::VOL_BITS-1:0]       volume_q;
	logic                                saturated_q;

	// low COORD_BITS of the 16-bit field, sign-extended
	function automatic logic signed [CW-1:0] to_coord(
		input logic signed [tpva_pkg::COORD_IN_BITS-1:0] x);
		logic [EXT-1:0] z;
		z = EXT'($unsigned(x));
		return signed'(z[CW-1:0]);
	endfunction

	function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return DW'(a) - DW'(b);
	endfunction

	// capture the new triangle, then keep it as the previous one
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q[0][0] <= to_coord(ax);
			cur_q[0][1] <= to_coord(ay);
			cur_q[0][2] <= to_coord(az);
			cur_q[1][0] <= to_coord(bx);
			cur_q[1][1] <= to_coord(by_coord);
			cur_q[1][2] <= to_coord(bz);
			cur_q[2][0] <= to_coord(cx);
			cur_q[2][1] <= to_coord(cy);
			cur_q[2][2] <= to_coord(cz);
		end
		if (cmd.store_prev) begin
			prev_q <= cur_q;
		end
	end

	// edge vectors of the next tetrahedron: a,b,c are previous corners, d,e,f new ones
	always_ff @(posedge clk) begin
		if (cmd.load_diff) begin
			for (int c = 0; c < 3; c++) begin
				case (cmd.tet)
					tpva_pkg::TET_ADEF: begin
						v_q[c] <= dif(cur_q[0][c], prev_q[0][c]);
						w_q[c] <= dif(cur_q[1][c], prev_q[0][c]);
						u_q[c] <= dif(cur_q[2][c], prev_q[0][c]);
					end
					tpva_pkg::TET_CEFA: begin
						v_q[c] <= dif(cur_q[1][c], prev_q[2][c]);
						w_q[c] <= dif(cur_q[2][c], prev_q[2][c]);
						u_q[c] <= dif(prev_q[0][c], prev_q[2][c]);
					end
					default: begin
						v_q[c] <= dif(prev_q[1][c], prev_q[0][c]);
						w_q[c] <= dif(prev_q[2][c], prev_q[0][c]);
						u_q[c] <= dif(cur_q[1][c], prev_q[0][c]);
					end
				endcase
			end
		end
	end

	// operand select
	always_comb begin
		case (cmd.uop.a_vec)
			tpva_pkg::VEC_U: opa = u_q[cmd.uop.a_comp];
			tpva_pkg::VEC_V: opa = v_q[cmd.uop.a_comp];
			tpva_pkg::VEC_W: opa = w_q[cmd.uop.a_comp];
			default:         opa = '0;
		endcase
		case (cmd.uop.b_vec)
			tpva_pkg::VEC_V: opb = XW'(v_q[cmd.uop.b_comp]);
			tpva_pkg::VEC_W: opb = XW'(w_q[cmd.uop.b_comp]);
			tpva_pkg::VEC_X: opb = x_q[cmd.uop.b_comp];
			default:         opb = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		opa_s1  <= opa;
		opb_s1  <= opb;
		uop_s1  <= cmd.uop;
		prod_s2 <= opa_s1 * opb_s1;
		uop_s2  <= uop_s1;
		abs_s4  <= t_q[TW-1] ? TW'(-t_q) : TW'(t_q);
	end

	// cross-product and triple-product accumulators
	always_ff @(posedge clk) begin
		if (v_s2) begin
			case (uop_s2.dst)
				tpva_pkg::DST_X0: x_q[0] <= (uop_s2.mode == tpva_pkg::MD_SUB) ?
					x_q[0] - XW'(prod_s2) : XW'(prod_s2);
				tpva_pkg::DST_X1: x_q[1] <= (uop_s2.mode == tpva_pkg::MD_SUB) ?
					x_q[1] - XW'(prod_s2) : XW'(prod_s2);
				tpva_pkg::DST_X2: x_q[2] <= (uop_s2.mode == tpva_pkg::MD_SUB) ?
					x_q[2] - XW'(prod_s2) : XW'(prod_s2);
				default: t_q <= (uop_s2.mode == tpva_pkg::MD_ADD) ?
					t_q + TW'(prod_s2) : TW'(prod_s2);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			tend_s3  <= 1'b0;
			abs_v_s4 <= 1'b0;
		end else begin
			v_s1     <= cmd.issue;
			v_s2     <= v_s1;
			tend_s3  <= v_s2 && uop_s2.tet_end;
			abs_v_s4 <= tend_s3;
		end
	end

	// running sum of six times the volume, saturating
	assign sum_ext = {1'b0, sum_q} + (SB + 1)'(abs_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sat_q       <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			if (cmd.clear || cmd.out_load) begin
				sum_q <= '0;
				sat_q <= 1'b0;
			end else if (abs_v_s4) begin
				if (sum_ext[SB]) begin
					sum_q <= '1;
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SB-1:0];
				end
			end
			if (cmd.clear || cmd.out_load) begin
				have_prev_q <= 1'b0;
			end else if (cmd.store_prev) begin
				have_prev_q <= 1'b1;
			end
		end
	end

	// divide by six, top hex digit first
	assign dig  = {rem_q, div_q[SB-1 -: tpva_pkg::DIV_DIGIT]};
	assign qdig = tpva_pkg::quo6(dig);
	assign qmul = tpva_pkg::DIG_BITS'(qdig) * tpva_pkg::DIG_BITS'(tpva_pkg::DIVISOR);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_q <= sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			div_q <= {div_q[SB-tpva_pkg::DIV_DIGIT-1:0], qdig};
			rem_q <= tpva_pkg::REM_BITS'(dig - qmul);
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			volume_q    <= div_q[tpva_pkg::VOL_BITS-1:0];
			saturated_q <= sat_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.volume    = volume_q;
	assign result.saturated = saturated_q;

	assign status.busy      = v_s1 | v_s2 | tend_s3 | abs_v_s4;
	assign status.have_prev = have_prev_q;
	assign status.out_free  = !out_valid_q || result.ready;

	a_sat_pins_sum: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> (sum_q == '1))
		else $error("saturation flag set but sum not pinned at full scale");

	a_out_follows_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (result.valid && result.saturated == $past(sat_q)))
		else $error("result word not presented after load");

endmodule

`default_nettype wire

// ===== sv/tube_prism_volume_accumulator.sv =====
// top level of the stream tube prism volume accumulator
`default_nettype none

// Each triangle word carries three corners in signed Q8.8. The block keeps the previous
// triangle and adds the prism between it and the new one as three tetrahedra (ABCE, ADEF,
// CEFA), each the magnitude of an exact triple product; the sum saturates at 2^64-1 and
// raises saturated. A word with last set emits one result: the sum divided by six, in Q24.
// All 27 products of a prism go through one shared multiplier, one product per cycle within
// a tetrahedron, after a step that loads its edge vectors; ready returns once all products
// have landed in the sum. A word with last set then adds a divide (one hex digit per cycle)
// and a step to load the result register, plus any wait for the previous result to be taken.
// The result register lets a new triangle be accepted while a volume is still waiting
// downstream.
module tube_prism_volume_accumulator #(
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tpva_tri_if.sink      triangle,
	tpva_res_if.source    result
);

	tpva_pkg::cmd_t    cmd;
	tpva_pkg::status_t status;
	logic              ready;

	tpva_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (triangle.valid),
		.first  (triangle.first),
		.last   (triangle.last),
		.ready  (ready),
		.status (status),
		.cmd    (cmd)
	);

	assign triangle.ready = ready;

	tpva_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ax       (triangle.ax),
		.ay       (triangle.ay),
		.az       (triangle.az),
		.bx       (triangle.bx),
		.by_coord (triangle.by_coord),
		.bz       (triangle.bz),
		.cx       (triangle.cx),
		.cy       (triangle.cy),
		.cz       (triangle.cz),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== test/tpva_volume_checker.sv =====
// checker for the tube volume accumulator: predicts every tube volume and compares the result words
`default_nettype none

module tpva_volume_checker #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	tpva_tri_if  triangle_mon,
	tpva_res_if  result_mon,
	output int   errors,
	output int   pending
);

	localparam int COORD_IN_BITS = tpva_pkg::COORD_IN_BITS;
	localparam int SUM_BITS      = tpva_pkg::SUM_BITS;
	localparam int VOL_BITS      = tpva_pkg::VOL_BITS;
	localparam int DIVISOR       = tpva_pkg::DIVISOR;

	typedef struct {
		logic [VOL_BITS-1:0] volume;
		logic                saturated;
	} tube_volume_t;

	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

	tube_volume_t             volume_q[$];
	logic [COORD_IN_BITS-1:0] prev_tri [9];
	logic                     have_prev;
	logic [SUM_BITS-1:0]      six_vol;
	logic                     sat;

	// only the low COORD_BITS of a coordinate count, sign-extended
	function automatic longint coord_val(input logic [COORD_IN_BITS-1:0] raw);
		longint v;
		v = longint'(raw);
		return (v <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
	endfunction

	// |(q-p) . ((r-p) x (s-p))|, six times the volume of tetrahedron p,r,s,q
	function automatic logic [SUM_BITS-1:0] tet_six_volume(input longint p[3], input longint r[3],
		input longint s[3], input longint q[3]);
		longint u[3], v[3], w[3], x[3];
		longint t;
		for (int i = 0; i < 3; i++) begin
			u[i] = q[i] - p[i];
			v[i] = r[i] - p[i];
			w[i] = s[i] - p[i];
		end
		x[0] = v[1] * w[2] - w[1] * v[2];
		x[1] = v[2] * w[0] - w[2] * v[0];
		x[2] = v[0] * w[1] - w[0] * v[1];
		t = u[0] * x[0] + u[1] * x[1] + u[2] * x[2];
		return SUM_BITS'(t < 0 ? -t : t);
	endfunction

	task automatic take_triangle();
		logic [COORD_IN_BITS-1:0] raw [9];
		longint a[3], b[3], c[3], d[3], e[3], f[3];
		logic [SUM_BITS-1:0] prism;
		logic [SUM_BITS:0]   total;
		tube_volume_t        vol;
		raw = '{triangle_mon.ax, triangle_mon.ay, triangle_mon.az,
			triangle_mon.bx, triangle_mon.by_coord, triangle_mon.bz,
			triangle_mon.cx, triangle_mon.cy, triangle_mon.cz};
		if (triangle_mon.first) begin
			six_vol = '0;
			sat = 1'b0;
			have_prev = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			d[i] = coord_val(raw[i]);
			e[i] = coord_val(raw[3 + i]);
			f[i] = coord_val(raw[6 + i]);
			a[i] = coord_val(prev_tri[i]);
			b[i] = coord_val(prev_tri[3 + i]);
			c[i] = coord_val(prev_tri[6 + i]);
		end
		if (have_prev) begin
			// prism split as abce, adef, cefa
			prism = tet_six_volume(a, b, c, e) + tet_six_volume(a, d, e, f)
				+ tet_six_volume(c, e, f, a);
			total = {1'b0, six_vol} + {1'b0, prism};
			if (total[SUM_BITS]) begin
				six_vol = SUM_MAX;
				sat = 1'b1;
			end else begin
				six_vol = total[SUM_BITS-1:0];
			end
		end
		prev_tri = raw;
		have_prev = 1'b1;
		if (triangle_mon.last) begin
			vol.volume = VOL_BITS'(six_vol / SUM_BITS'(DIVISOR));
			vol.saturated = sat;
			volume_q.push_back(vol);
			six_vol = '0;
			sat = 1'b0;
			have_prev = 1'b0;
		end
	endtask

	task automatic check_result();
		tube_volume_t exp_vol;
		if (volume_q.size() == 0) begin
			$error("result word with no volume pending: volume %0d saturated %0b",
				result_mon.volume, result_mon.saturated);
			errors++;
		end else begin
			exp_vol = volume_q.pop_front();
			if (result_mon.volume !== exp_vol.volume) begin
				$error("volume: expected %0d, got %0d", exp_vol.volume, result_mon.volume);
				errors++;
			end
			if (result_mon.saturated !== exp_vol.saturated) begin
				$error("saturated: expected %0b, got %0b", exp_vol.saturated,
					result_mon.saturated);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				prev_tri[i] = '0;
			have_prev = 1'b0;
			six_vol = '0;
			sat = 1'b0;
			volume_q.delete();
		end else begin
			if (triangle_mon.valid && triangle_mon.ready)
				take_triangle();
			if (result_mon.valid && result_mon.ready)
				check_result();
		end
		pending = volume_q.size();
	end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench top: clock, reset, triangle stimulus, result back-pressure and the verdict
`default_nettype none

module tb_top;

	localparam int COORD_BITS   = 16;
	localparam int RANDOM_WORDS = 1035;
	// long tube of maximal prisms to build up a large sum
	localparam int BIG_WORDS    = 200;
	localparam int HOLD_CYCLES  = 3000;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef logic signed [tpva_pkg::COORD_IN_BITS-1:0] coord_t;
	typedef coord_t corners_t [9];

	localparam coord_t CMIN = 16'sh8000;
	localparam coord_t CMAX = 16'sh7fff;
	// cube corners forming a regular tetrahedron, bit 0 x, bit 1 y, bit 2 z
	localparam logic [2:0] CUBE_VERTEX [4] = '{3'b000, 3'b011, 3'b101, 3'b110};

	logic clk = 1'b0;
	logic arst_n;
	logic calm;
	logic hold_start;
	logic hold_done;
	int   cycles = 0;
	int   errors;
	int   pending;

	tpva_tri_if triangle ();
	tpva_res_if result ();

	tube_prism_volume_accumulator #(
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.triangle (triangle),
		.result   (result)
	);

	tpva_volume_checker #(
		.COORD_BITS(COORD_BITS)
	) volume_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.triangle_mon (triangle),
		.result_mon   (result),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off so the block backs up
	initial begin
		result.ready <= 1'b0;
		hold_done <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_start && !hold_done) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done <= 1'b1;
			end
			result.ready <= calm || ($urandom_range(0, 99) >= 20);
		end
	end

	function automatic coord_t pick_coord(input int kind);
		case (kind)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 511)) - 16'sd256;
			default: return $urandom_range(0, 1) ? CMAX : CMIN;
		endcase
	endfunction

	function automatic corners_t random_triangle();
		corners_t c;
		int       style;
		style = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			c[i] = pick_coord(style < 6 ? 0 : (style < 8 ? 1 : 2));
		// collapsed triangle, all corners on one point
		if (style == 9) begin
			for (int i = 3; i < 9; i++)
				c[i] = c[i % 3];
		end
		return c;
	endfunction

	function automatic corners_t cube_triangle(input int va, input int vb, input int vc);
		corners_t c;
		int       idx [3];
		idx = '{va, vb, vc};
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++)
				c[3 * k + j] = CUBE_VERTEX[idx[k]][j] ? CMAX : CMIN;
		end
		return c;
	endfunction

	task automatic send_triangle(input corners_t c, input logic first, input logic last);
		if (!calm && $urandom_range(0, 99) < 20) begin
			triangle.valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		triangle.ax <= c[0];
		triangle.ay <= c[1];
		triangle.az <= c[2];
		triangle.bx <= c[3];
		triangle.by_coord <= c[4];
		triangle.bz <= c[5];
		triangle.cx <= c[6];
		triangle.cy <= c[7];
		triangle.cz <= c[8];
		triangle.first <= first;
		triangle.last <= last;
		triangle.valid <= 1'b1;
		do @(posedge clk); while (!triangle.ready);
	endtask

	initial begin
		int va, vb, vc, vd;
		int sent, len;
		arst_n <= 1'b0;
		calm <= 1'b0;
		hold_start <= 1'b0;
		triangle.valid <= 1'b0;
		triangle.ax <= '0;
		triangle.ay <= '0;
		triangle.az <= '0;
		triangle.bx <= '0;
		triangle.by_coord <= '0;
		triangle.bz <= '0;
		triangle.cx <= '0;
		triangle.cy <= '0;
		triangle.cz <= '0;
		triangle.first <= 1'b0;
		triangle.last <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing stored after reset: the word starts a tube without first
		send_triangle(cube_triangle(0, 1, 2), 1'b0, 1'b0);
		// largest prism
		send_triangle(cube_triangle(2, 3, 1), 1'b0, 1'b1);
		// one-triangle tube
		send_triangle(cube_triangle(1, 2, 3), 1'b1, 1'b1);
		// extremes per field
		send_triangle('{default: CMIN}, 1'b1, 1'b0);
		send_triangle('{default: CMAX}, 1'b0, 1'b0);
		send_triangle('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}, 1'b0, 1'b0);
		send_triangle('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}, 1'b0, 1'b0);
		send_triangle('{default: coord_t'(0)}, 1'b0, 1'b1);
		// first inside a running tube drops what was summed
		send_triangle(random_triangle(), 1'b1, 1'b0);
		send_triangle(random_triangle(), 1'b0, 1'b0);
		send_triangle(random_triangle(), 1'b1, 1'b0);
		send_triangle(random_triangle(), 1'b0, 1'b1);
		// after a last, a word without first starts the next tube
		send_triangle(random_triangle(), 1'b0, 1'b0);
		send_triangle(random_triangle(), 1'b0, 1'b0);
		send_triangle(random_triangle(), 1'b0, 1'b1);

		// long tube of maximal prisms
		va = 0;
		vb = 1;
		vc = 2;
		for (int k = 0; k < BIG_WORDS; k++) begin
			send_triangle(cube_triangle(va, vb, vc), k == 0, k == BIG_WORDS - 1);
			vd = 6 - va - vb - vc;
			va = vc;
			vc = vb;
			vb = vd;
		end

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			calm <= (sent >= 500 && sent < 800);
			if (sent >= 200 && !hold_start)
				hold_start <= 1'b1;
			if ($urandom_range(0, 99) < 80) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
				for (int k = 0; k < len; k++) begin
					send_triangle(random_triangle(), k == 0, k == len - 1);
					sent++;
				end
			end else begin
				send_triangle(random_triangle(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				sent++;
			end
		end
		triangle.valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
